>>> rtl/rpl_pkg.sv
// ============================================================================
// rpl_pkg: shared types and constants of the block RMS / peak level meter
// Register indexes, register reset values and the level mode encoding.
// ============================================================================
`default_nettype none

package rpl_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 24;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_MODE   = 1'b1;

    // Width and reset value of the block length register.
    localparam int                       BLOCK_REG_BITS     = 24;
    localparam logic [BLOCK_REG_BITS-1:0] BLOCK_LENGTH_RESET = 24'd800;

    // The square sum is at most this many bits wide and saturates at all ones of its width.
    localparam int MAX_ACC_BITS = 64;

    typedef enum logic {
        LEVEL_RMS  = 1'b0,
        LEVEL_PEAK = 1'b1
    } t_level_mode;

endpackage

`default_nettype wire

>>> rtl/rpl_stream_if.sv
// ============================================================================
// rpl_stream_if: valid/ready stream channel
// Carries one payload word per request from a source to a sink.
// ============================================================================
`default_nettype none

interface rpl_stream_if #(
    parameter int WIDTH = 16
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rpl_front.sv
// ============================================================================
// rpl_front: sample intake and block accumulation
// Takes samples, squares them, keeps the block sums and posts a finished block.
// ============================================================================
`default_nettype none

module rpl_front
    import rpl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24,
    parameter int ACC_BITS    = 54
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [BLOCK_REG_BITS-1:0] i_block_length,
    input  wire t_level_mode               i_level_mode,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [SAMPLE_BITS-1:0]    i_sample,
    output logic                           o_push,
    input  wire logic                      i_push_ready,
    output logic [ACC_BITS-1:0]            o_job_sum,
    output logic [COUNT_BITS-1:0]          o_job_length,
    output logic                           o_job_mode,
    output logic [SAMPLE_BITS-1:0]         o_job_peak
);

    localparam int SQ_BITS  = 2 * SAMPLE_BITS - 1;
    localparam int LEN_BITS = (COUNT_BITS < BLOCK_REG_BITS) ? COUNT_BITS : BLOCK_REG_BITS;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQUARE,
        F_ACCUM
    } t_front_state;

    t_front_state           r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_mag, n_mag;
    logic [SQ_BITS-1:0]     r_sq, n_sq;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [ACC_BITS-1:0]    r_sum, n_sum;
    logic [SAMPLE_BITS-1:0] r_peak, n_peak;

    logic [COUNT_BITS-1:0]  count_inc;
    logic [COUNT_BITS-1:0]  length_raw;
    logic [COUNT_BITS-1:0]  length_eff;
    logic [ACC_BITS:0]      sum_wide;
    logic [ACC_BITS-1:0]    sum_sat;
    logic [SAMPLE_BITS-1:0] peak_upd;
    logic                   block_end;
    logic                   commit;

    // A block length of zero behaves as one.
    assign length_raw = COUNT_BITS'(i_block_length[LEN_BITS-1:0]);
    assign length_eff = (length_raw == '0) ? COUNT_BITS'(1) : length_raw;
    assign count_inc  = r_count + COUNT_BITS'(1);
    assign block_end  = (count_inc >= length_eff);

    assign sum_wide = {1'b0, r_sum} + (ACC_BITS + 1)'(r_sq);
    assign sum_sat  = sum_wide[ACC_BITS] ? '1 : sum_wide[ACC_BITS-1:0];
    assign peak_upd = (r_mag > r_peak) ? r_mag : r_peak;

    // The accumulate step waits while a finished block finds the queue full.
    assign commit = (r_state == F_ACCUM) && (!block_end || i_push_ready);

    assign o_ready      = (r_state == F_IDLE);
    assign o_push       = (r_state == F_ACCUM) && block_end && i_push_ready;
    assign o_job_sum    = sum_sat;
    assign o_job_length = length_eff;
    assign o_job_mode   = i_level_mode;
    assign o_job_peak   = peak_upd;

    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_sq    = r_sq;
        n_count = r_count;
        n_sum   = r_sum;
        n_peak  = r_peak;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    // Two's complement negate; the most negative code maps to its
                    // magnitude, which still fits as an unsigned value.
                    n_mag   = i_sample[SAMPLE_BITS-1] ? (~i_sample + SAMPLE_BITS'(1))
                                                      : i_sample;
                    n_state = F_SQUARE;
                end
            end
            F_SQUARE: begin
                n_sq    = SQ_BITS'(r_mag * r_mag);
                n_state = F_ACCUM;
            end
            F_ACCUM: begin
                if (commit) begin
                    n_state = F_IDLE;
                    if (block_end) begin
                        n_count = '0;
                        n_sum   = '0;
                        n_peak  = '0;
                    end else begin
                        n_count = count_inc;
                        n_sum   = sum_sat;
                        n_peak  = peak_upd;
                    end
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_sq  <= n_sq;
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            r_peak  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_peak  <= n_peak;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rpl_queue.sv
// ============================================================================
// rpl_queue: two-entry job queue
// Holds finished blocks between the accumulator and the level unit.
// ============================================================================
`default_nettype none

module rpl_queue #(
    parameter int WIDTH = 95
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_entry [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_fill, n_fill;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rpl_back.sv
// ============================================================================
// rpl_back: level computation
// In RMS mode divides the square sum by the block length one bit per cycle and takes
// the square root two radicand bits per cycle, in peak mode passes the peak, and holds the level until it is taken.
// ============================================================================
`default_nettype none

module rpl_back
    import rpl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24,
    parameter int ACC_BITS    = 54
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_job_valid,
    output logic                        o_job_pop,
    input  wire logic [ACC_BITS-1:0]    i_job_sum,
    input  wire logic [COUNT_BITS-1:0]  i_job_length,
    input  wire logic                   i_job_mode,
    input  wire logic [SAMPLE_BITS-1:0] i_job_peak,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [SAMPLE_BITS-1:0]      o_level
);

    localparam int ROOT_BITS = (ACC_BITS + 1) / 2;
    localparam int SRC_BITS  = 2 * ROOT_BITS;
    localparam int STEP_BITS = $clog2(ACC_BITS + 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIVIDE,
        B_ROOT,
        B_OUT
    } t_back_state;

    t_back_state            r_state, n_state;
    logic [STEP_BITS-1:0]   r_step, n_step;
    logic [ACC_BITS-1:0]    r_quo, n_quo;
    logic [COUNT_BITS-1:0]  r_den, n_den;
    logic [COUNT_BITS-1:0]  r_rem, n_rem;
    logic [SRC_BITS-1:0]    r_src, n_src;
    logic [ROOT_BITS+1:0]   r_srem, n_srem;
    logic [ROOT_BITS-1:0]   r_root, n_root;
    logic [SAMPLE_BITS-1:0] r_level, n_level;

    logic [COUNT_BITS:0]    div_part;
    logic                   div_ge;
    logic [ROOT_BITS+3:0]   root_part;
    logic [ROOT_BITS+3:0]   root_trial;
    logic                   root_ge;

    // Restoring divide step: bring down the next dividend bit.
    assign div_part = {r_rem, r_quo[ACC_BITS-1]};
    assign div_ge   = (div_part >= {1'b0, r_den});

    // Digit-by-digit root step: bring down two radicand bits, try 4*root+1.
    assign root_part  = {r_srem, r_src[SRC_BITS-1 -: 2]};
    assign root_trial = (ROOT_BITS + 4)'({r_root, 2'b01});
    assign root_ge    = (root_part >= root_trial);

    assign o_job_pop = (r_state == B_IDLE) && i_job_valid;
    assign o_valid   = (r_state == B_OUT);
    assign o_level   = r_level;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_quo   = r_quo;
        n_den   = r_den;
        n_rem   = r_rem;
        n_src   = r_src;
        n_srem  = r_srem;
        n_root  = r_root;
        n_level = r_level;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    if (t_level_mode'(i_job_mode) == LEVEL_PEAK) begin
                        n_level = i_job_peak;
                        n_state = B_OUT;
                    end else begin
                        n_quo   = i_job_sum;
                        n_den   = i_job_length;
                        n_rem   = '0;
                        n_step  = STEP_BITS'(ACC_BITS);
                        n_state = B_DIVIDE;
                    end
                end
            end
            B_DIVIDE: begin
                n_rem  = div_ge ? COUNT_BITS'(div_part - {1'b0, r_den})
                                : COUNT_BITS'(div_part);
                n_quo  = {r_quo[ACC_BITS-2:0], div_ge};
                n_step = r_step - STEP_BITS'(1);
                if (r_step == STEP_BITS'(1)) begin
                    n_src   = SRC_BITS'({r_quo[ACC_BITS-2:0], div_ge});
                    n_srem  = '0;
                    n_root  = '0;
                    n_step  = STEP_BITS'(ROOT_BITS);
                    n_state = B_ROOT;
                end
            end
            B_ROOT: begin
                n_srem = root_ge ? (ROOT_BITS + 2)'(root_part - root_trial)
                                 : (ROOT_BITS + 2)'(root_part);
                n_root = {r_root[ROOT_BITS-2:0], root_ge};
                n_src  = {r_src[SRC_BITS-3:0], 2'b00};
                n_step = r_step - STEP_BITS'(1);
                if (r_step == STEP_BITS'(1)) begin
                    n_level = SAMPLE_BITS'({r_root[ROOT_BITS-2:0], root_ge});
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (i_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_quo   <= n_quo;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_src   <= n_src;
        r_srem  <= n_srem;
        r_root  <= n_root;
        r_level <= n_level;
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/block_rms_peak_level.sv
// Each sample goes through capture, square and accumulate before the intake takes the
// next; the accumulate step waits while the job queue is full, so when every sample
// closes an RMS block the level unit sets the pace. In RMS mode the level unit divides
// the ACC-bit sum and takes a ROOT-bit root (ACC = 2*SAMPLE_BITS-2+COUNT_BITS capped at 64,
// ROOT = (ACC+1)/2; 54 and 27 at the default sizes); in peak mode it passes the peak through.
// Reset is synchronous, active low; it clears the block sums and all control.
// ============================================================================
// block_rms_peak_level: block RMS / peak level meter
// Accumulates signed audio samples per block and reports the RMS or peak level.
// ============================================================================
`default_nettype none

module block_rms_peak_level
    import rpl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    rpl_stream_if.sink                     i_sample,
    rpl_stream_if.source                   o_level
);

    // A square is at most 2**(2*SAMPLE_BITS-2), so the sum of squares needs 2*SAMPLE_BITS-2
    // bits plus room for the largest count; beyond 64 bits it saturates instead of growing.
    localparam int SUM_FULL_BITS = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
    localparam int ACC_BITS      = (SUM_FULL_BITS > MAX_ACC_BITS) ? MAX_ACC_BITS
                                                                  : SUM_FULL_BITS;
    localparam int JOB_BITS      = ACC_BITS + COUNT_BITS + 1 + SAMPLE_BITS;

    // Configuration registers. User writes must not disturb the running block; unenforced.
    logic [BLOCK_REG_BITS-1:0] r_block_length;
    t_level_mode               r_level_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLOCK_LENGTH_RESET;
            r_level_mode   <= LEVEL_RMS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLOCK_LENGTH: r_block_length <= i_cfg_data[BLOCK_REG_BITS-1:0];
                REG_LEVEL_MODE:   r_level_mode   <= t_level_mode'(i_cfg_data[0]);
                default: begin
                end
            endcase
        end
    end

    // Front: sample intake and block accumulation. A finished block is posted
    // as one job holding the sum, the effective length, the mode and the peak.
    logic                   front_push;
    logic                   queue_full;
    logic [ACC_BITS-1:0]    front_sum;
    logic [COUNT_BITS-1:0]  front_length;
    logic                   front_mode;
    logic [SAMPLE_BITS-1:0] front_peak;

    rpl_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_block_length (r_block_length),
        .i_level_mode   (r_level_mode),
        .i_valid        (i_sample.valid),
        .o_ready        (i_sample.ready),
        .i_sample       (i_sample.data[SAMPLE_BITS-1:0]),
        .o_push         (front_push),
        .i_push_ready   (!queue_full),
        .o_job_sum      (front_sum),
        .o_job_length   (front_length),
        .o_job_mode     (front_mode),
        .o_job_peak     (front_peak)
    );

    // Queue between the two halves.
    logic                queue_valid;
    logic                queue_pop;
    logic [JOB_BITS-1:0] queue_data;

    rpl_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  ({front_sum, front_length, front_mode, front_peak}),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_data)
    );

    // Back: divide and square root for RMS, or pass the peak through. The
    // level register doubles as the output stage of the result channel.
    rpl_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (queue_valid),
        .o_job_pop    (queue_pop),
        .i_job_sum    (queue_data[JOB_BITS-1 -: ACC_BITS]),
        .i_job_length (queue_data[SAMPLE_BITS+1 +: COUNT_BITS]),
        .i_job_mode   (queue_data[SAMPLE_BITS]),
        .i_job_peak   (queue_data[SAMPLE_BITS-1:0]),
        .o_valid      (o_level.valid),
        .i_ready      (o_level.ready),
        .o_level      (o_level.data[SAMPLE_BITS-1:0])
    );

endmodule

`default_nettype wire

>>> rtl/rpl_checker.sv
// ============================================================================
// rpl_checker: port-level checks of the level meter
// Watches the sample and level channels and flags illegal behavior.
// ============================================================================
`default_nettype none

module rpl_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [SAMPLE_BITS-1:0] i_out_data
);

    localparam logic [SAMPLE_BITS-1:0] LEVEL_MAX = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    // A pending level stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("level request dropped before it was taken");

    // A stalled level keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_data))
        else $error("level changed while stalled");

    // A level never exceeds full scale.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data <= LEVEL_MAX))
        else $error("level above full scale");

    // The intake drops ready after each sample it takes.
    a_in_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("sample intake ready right after a sample");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("level offered right after reset");

endmodule

bind block_rms_peak_level rpl_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_rpl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_level.valid),
    .i_out_ready (o_level.ready),
    .i_out_data  (o_level.data[SAMPLE_BITS-1:0])
);

`default_nettype wire
